/* design/iral_pkg.sv */
`timescale 1ns / 1ps
// Shared codes for the interval room allocator.
// No dependencies; imported by iral_cmp and interval_room_allocator.
package iral_pkg;

	// Which key of the compare unit is the smallest.
	typedef logic [1:0] sel_t;

	localparam sel_t SEL_ITEM = 2'd0;
	localparam sel_t SEL_A    = 2'd1;
	localparam sel_t SEL_B    = 2'd2;

endpackage

/* design/iral_ram.sv */
`timescale 1ns / 1ps
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module iral_ram #(
	parameter int WIDTH = 43,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

/* design/iral_cmp.sv */
`timescale 1ns / 1ps
// Shared key compare unit: picks the smallest of the moving entry and up
// to two heap entries. Keys are {departure, room}. Depends on iral_pkg.
module iral_cmp import iral_pkg::*; #(
	parameter int W = 43
) (
	input  logic [W-1:0] item,
	input  logic [W-1:0] cand_a,
	input  logic         a_ok,
	input  logic [W-1:0] cand_b,
	input  logic         b_ok,
	output sel_t         sel
);

	logic a_lt_i;
	logic b_lt_i;
	logic b_lt_a;
	logic a_win;
	logic b_win;

	// three compares in parallel, then select
	assign a_lt_i = cand_a < item;
	assign b_lt_i = cand_b < item;
	assign b_lt_a = cand_b < cand_a;

	assign a_win = a_ok && a_lt_i && (!b_ok || !b_lt_a);
	assign b_win = b_ok && b_lt_i && (!a_ok || b_lt_a);

	always_comb begin
		if (a_win) begin
			sel = SEL_A;
		end else if (b_win) begin
			sel = SEL_B;
		end else begin
			sel = SEL_ITEM;
		end
	end

endmodule

/* design/interval_room_allocator.sv */
`timescale 1ns / 1ps
// Interval room allocator, top level. Depends on iral_pkg, iral_ram, iral_cmp.
//
// Assigns each interval (given in arrival order) a room, keeping the open
// rooms in a binary min-heap keyed by {departure, room} held in a two-read-port
// RAM. A room whose earliest departure is before the arrival is reused and
// sifted down; otherwise a new room is opened and sifted up; with MAX_ROOMS
// rooms open such an item returns room 0 with overflow set. One shared compare
// unit handles one heap level per cycle, both children being fetched at once.
// An item holds the input from its accept through START, the levels visited
// (at most log2(MAX_ROOMS) + 1) and FIN, where it also waits while a still-full
// output register is held by out_stall; its result is then registered out.
// in_stall is high while an item is worked on; a finished result waits in the
// output register while the next item is taken. No clearing pass after reset.
module interval_room_allocator import iral_pkg::*; #(
	parameter int MAX_ROOMS = 1024,
	parameter int TIME_BITS = 32,
	parameter int TAG_BITS  = 18
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [TIME_BITS-1:0]               arrival,
	input  logic [TIME_BITS-1:0]               departure,
	input  logic [TAG_BITS-1:0]                tag,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [TAG_BITS-1:0]                tag_out,
	output logic [$clog2(MAX_ROOMS+1)-1:0]     room,
	output logic [$clog2(MAX_ROOMS+1)-1:0]     rooms_used,
	output logic                               overflow
);

	localparam int AW = $clog2(MAX_ROOMS);
	localparam int CW = $clog2(MAX_ROOMS + 1);
	localparam int RW = CW;
	localparam int EW = TIME_BITS + RW;
	localparam int IW = AW + 2;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_UP    = 3'd2;
	localparam logic [2:0] ST_DN    = 3'd3;
	localparam logic [2:0] ST_PUT   = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	logic [2:0]           state_q, state_d;
	logic [CW-1:0]        count_q, count_d;
	logic                 out_valid_q;
	logic                 load_out;

	logic [TIME_BITS-1:0] arrival_q;
	logic [TIME_BITS-1:0] dep_q;
	logic [TAG_BITS-1:0]  tag_q;
	logic [EW-1:0]        item_q, item_d;
	logic [EW-1:0]        root_q;
	logic [AW-1:0]        pos_q, pos_d;
	logic [RW-1:0]        res_room_q, res_room_d;
	logic                 res_ovf_q, res_ovf_d;

	logic [TAG_BITS-1:0]  tag_out_q;
	logic [RW-1:0]        room_q;
	logic [CW-1:0]        used_q;
	logic                 ovf_q;

	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [EW-1:0]        wr_data;
	logic [AW-1:0]        rd_addr_a;
	logic [AW-1:0]        rd_addr_b;
	logic [EW-1:0]        rd_a;
	logic [EW-1:0]        rd_b;

	logic                 cmp_a_ok;
	logic                 cmp_b_ok;
	sel_t                 sel;

	logic [TIME_BITS-1:0] root_dep;
	logic [RW-1:0]        root_room;
	logic [RW-1:0]        room_new;
	logic [EW-1:0]        item_new;
	logic [CW-1:0]        cnt_parent;
	logic [AW-1:0]        pa;
	logic [AW-1:0]        pa2;
	logic [IW-1:0]        l_idx;
	logic [IW-1:0]        r_idx;
	logic                 l_ok;
	logic                 r_ok;
	logic [AW-1:0]        child;
	logic [EW-1:0]        child_ent;
	logic [IW-1:0]        cl_idx;
	logic [IW-1:0]        cr_idx;

	iral_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_ROOMS)
	) u_heap (
		.clk     (clk),
		.we      (wr_en),
		.waddr   (wr_addr),
		.wdata   (wr_data),
		.raddr_a (rd_addr_a),
		.rdata_a (rd_a),
		.raddr_b (rd_addr_b),
		.rdata_b (rd_b)
	);

	iral_cmp #(
		.W (EW)
	) u_cmp (
		.item   (item_q),
		.cand_a (rd_a),
		.a_ok   (cmp_a_ok),
		.cand_b (rd_b),
		.b_ok   (cmp_b_ok),
		.sel    (sel)
	);

	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;
	assign tag_out    = tag_out_q;
	assign room       = room_q;
	assign rooms_used = used_q;
	assign overflow   = ovf_q;

	assign root_dep  = root_q[EW-1 -: TIME_BITS];
	assign root_room = root_q[RW-1:0];
	assign room_new  = count_q + 1'b1;
	assign item_new  = {dep_q, room_new};

	// heap index arithmetic: parent = (i-1)/2, children = 2i+1, 2i+2
	assign cnt_parent = (count_q - 1'b1) >> 1;
	assign pa         = (pos_q - 1'b1) >> 1;
	assign pa2        = (pa - 1'b1) >> 1;
	assign l_idx      = {1'b0, pos_q, 1'b1};
	assign r_idx      = l_idx + 1'b1;
	assign l_ok       = l_idx < IW'(count_q);
	assign r_ok       = r_idx < IW'(count_q);
	assign child      = (sel == SEL_A) ? l_idx[AW-1:0] : r_idx[AW-1:0];
	assign child_ent  = (sel == SEL_A) ? rd_a : rd_b;
	assign cl_idx     = {1'b0, child, 1'b1};
	assign cr_idx     = cl_idx + 1'b1;

	assign cmp_a_ok = (state_q == ST_UP) || ((state_q == ST_DN) && l_ok);
	assign cmp_b_ok = (state_q == ST_DN) && r_ok;

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		pos_d      = pos_q;
		item_d     = item_q;
		res_room_d = res_room_q;
		res_ovf_d  = res_ovf_q;
		load_out   = 1'b0;
		wr_en      = 1'b0;
		wr_addr    = pos_q;
		wr_data    = item_q;
		// children of the root by default, ready for a reuse
		rd_addr_a  = AW'(1);
		rd_addr_b  = AW'(2);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				if ((count_q == '0) || (root_dep >= arrival_q)) begin
					if (count_q == CW'(MAX_ROOMS)) begin
						res_room_d = '0;
						res_ovf_d  = 1'b1;
						state_d    = ST_FIN;
					end else begin
						item_d     = item_new;
						res_room_d = room_new;
						res_ovf_d  = 1'b0;
						count_d    = count_q + 1'b1;
						if (count_q == '0) begin
							wr_en   = 1'b1;
							wr_addr = '0;
							wr_data = item_new;
							state_d = ST_FIN;
						end else begin
							pos_d     = count_q[AW-1:0];
							rd_addr_a = cnt_parent[AW-1:0];
							state_d   = ST_UP;
						end
					end
				end else begin
					item_d     = {dep_q, root_room};
					res_room_d = root_room;
					res_ovf_d  = 1'b0;
					pos_d      = '0;
					state_d    = ST_DN;
				end
			end
			ST_UP: begin
				if (sel == SEL_ITEM) begin
					// new entry beats its parent: move the parent into the hole
					wr_en   = 1'b1;
					wr_data = rd_a;
					pos_d   = pa;
					if (pa == '0) begin
						state_d = ST_PUT;
					end else begin
						rd_addr_a = pa2;
					end
				end else begin
					wr_en   = 1'b1;
					state_d = ST_FIN;
				end
			end
			ST_DN: begin
				if (sel == SEL_ITEM) begin
					wr_en   = 1'b1;
					state_d = ST_FIN;
				end else begin
					wr_en     = 1'b1;
					wr_data   = child_ent;
					pos_d     = child;
					rd_addr_a = cl_idx[AW-1:0];
					rd_addr_b = cr_idx[AW-1:0];
				end
			end
			ST_PUT: begin
				wr_en   = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			arrival_q <= arrival;
			dep_q     <= departure;
			tag_q     <= tag;
		end
		item_q     <= item_d;
		pos_q      <= pos_d;
		res_room_q <= res_room_d;
		res_ovf_q  <= res_ovf_d;
		// shadow of heap entry 0
		if (wr_en && (wr_addr == '0)) begin
			root_q <= wr_data;
		end
		if (load_out) begin
			tag_out_q <= tag_q;
			room_q    <= res_room_q;
			used_q    <= count_q;
			ovf_q     <= res_ovf_q;
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ROOMS))
		else $error("room count above store size");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (count_q == $past(count_q)) || (count_q == $past(count_q) + 1'b1))
		else $error("room count moved by more than one");

	a_ovf_room: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (overflow == (room == '0)))
		else $error("overflow flag and room 0 disagree");

	a_room_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !overflow) |-> (room <= rooms_used))
		else $error("room number above rooms opened");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !wr_en)
		else $error("heap written while idle");
`endif

endmodule

/* sim/interval_room_allocator_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for interval_room_allocator: keeps its own room heap to
// predict each grant and checks every result item in order. Needs only the RTL.
module interval_room_allocator_tb;

	localparam int MAX_ROOMS = 1024;
	localparam int TIME_BITS = 32;
	localparam int TAG_BITS  = 18;
	localparam int ROOM_W    = $clog2(MAX_ROOMS + 1);
	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

	typedef struct {
		logic [TAG_BITS-1:0] tag;
		logic [ROOM_W-1:0]   room;
		logic [ROOM_W-1:0]   used;
		logic                overflow;
	} room_grant_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [TIME_BITS-1:0] arrival = '0;
	logic [TIME_BITS-1:0] departure = '0;
	logic [TAG_BITS-1:0]  tag = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [TAG_BITS-1:0]  tag_out;
	logic [ROOM_W-1:0]    room;
	logic [ROOM_W-1:0]    rooms_used;
	logic                 overflow;

	interval_room_allocator #(
		.MAX_ROOMS(MAX_ROOMS),
		.TIME_BITS(TIME_BITS),
		.TAG_BITS(TAG_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.arrival(arrival),
		.departure(departure),
		.tag(tag),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.tag_out(tag_out),
		.room(room),
		.rooms_used(rooms_used),
		.overflow(overflow)
	);

	// Predicted room heap, keyed by {departure, room}
	logic [TIME_BITS-1:0] heap_dep [MAX_ROOMS];
	logic [ROOM_W-1:0]    heap_room_no [MAX_ROOMS];
	int                   heap_size = 0;
	int                   next_room_no = 1;

	room_grant_t          grants_due[$];
	int                   errors = 0;
	logic [TIME_BITS-1:0] timeline = '0;
	bit                   send_burst = 1'b0;
	bit                   recv_burst = 1'b0;
	int                   hold_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#15_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic bit key_before(input int i, input int j);
		return heap_dep[i] < heap_dep[j] ||
			(heap_dep[i] == heap_dep[j] && heap_room_no[i] < heap_room_no[j]);
	endfunction

	function automatic void swap_slots(input int i, input int j);
		logic [TIME_BITS-1:0] d;
		logic [ROOM_W-1:0]    r;
		d = heap_dep[i];
		r = heap_room_no[i];
		heap_dep[i] = heap_dep[j];
		heap_room_no[i] = heap_room_no[j];
		heap_dep[j] = d;
		heap_room_no[j] = r;
	endfunction

	function automatic room_grant_t assign_room(input logic [TIME_BITS-1:0] arr,
			input logic [TIME_BITS-1:0] dep, input logic [TAG_BITS-1:0] t);
		room_grant_t g;
		int pos;
		int best;
		int kid;
		g.tag = t;
		g.room = '0;
		g.overflow = 1'b0;
		if (heap_size == 0 || heap_dep[0] >= arr) begin
			if (heap_size >= MAX_ROOMS) begin
				g.overflow = 1'b1;
			end else begin
				pos = heap_size;
				heap_dep[pos] = dep;
				heap_room_no[pos] = ROOM_W'(next_room_no);
				g.room = ROOM_W'(next_room_no);
				heap_size++;
				next_room_no++;
				while (pos > 0 && key_before(pos, (pos - 1) / 2)) begin
					swap_slots(pos, (pos - 1) / 2);
					pos = (pos - 1) / 2;
				end
			end
		end else begin
			// earliest-freeing room is reused and re-keyed
			g.room = heap_room_no[0];
			heap_dep[0] = dep;
			pos = 0;
			while (1) begin
				kid = 2 * pos + 1;
				best = pos;
				if (kid < heap_size && key_before(kid, best))
					best = kid;
				if (kid + 1 < heap_size && key_before(kid + 1, best))
					best = kid + 1;
				if (best == pos)
					break;
				swap_slots(pos, best);
				pos = best;
			end
		end
		g.used = ROOM_W'(heap_size);
		return g;
	endfunction

	// Mostly short gaps, a few long ones; none in burst mode
	function automatic int idle_len(input bit burst);
		int r;
		if (burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	// Called right after a rising edge; returns at the edge that takes the item
	task automatic send_interval(input logic [TIME_BITS-1:0] a,
			input logic [TIME_BITS-1:0] d, input logic [TAG_BITS-1:0] t);
		int gap;
		gap = idle_len(send_burst);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		arrival <= a;
		departure <= d;
		tag <= t;
		do @(posedge clk); while (in_stall);
		grants_due = {grants_due, assign_room(a, d, t)};
	endtask

	always @(posedge clk) begin : receiver
		int stall_left;
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles--;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
			stall_left = idle_len(recv_burst);
		end
	end

	always @(posedge clk) begin : result_check
		room_grant_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (grants_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result item: expected none, actual tag %0h room %0d",
					$time, tag_out, room);
			end else begin
				want = grants_due.pop_front();
				check_field("tag_out", want.tag, tag_out);
				check_field("room", want.room, room);
				check_field("rooms_used", want.used, rooms_used);
				check_field("overflow", want.overflow, overflow);
			end
		end
	end

	// Empty heap, equal departure and arrival, ties, extremes, unordered input
	task automatic test_directed_cases;
		int k;
		send_interval('0, '0, '0);
		send_interval('0, TIME_MAX, '1);
		send_interval(32'd1, 32'd5, 18'd1);
		send_interval(32'd5, 32'd5, 18'd2);
		send_interval(32'd6, 32'd9, 18'd3);
		send_interval(TIME_MAX, TIME_MAX, 18'd4);
		send_interval(32'hAAAA_AAAA, 32'h5555_5555, 18'h2AAAA);
		send_interval(32'h5555_5555, 32'hAAAA_AAAA, 18'h15555);
		for (k = 0; k < 5; k++)
			send_interval(32'd1000, 32'd1050, TAG_BITS'(16 + k));
		// equal departures: reuse must go to the lowest room
		for (k = 0; k < 3; k++)
			send_interval(32'd1051, 32'd1100 + k, TAG_BITS'(32 + k));
		send_interval(32'd1200, 32'd1100, 18'd40);
		timeline = 32'd1200;
	endtask

	task automatic test_random_schedules(input int n);
		logic [TIME_BITS-1:0] a;
		logic [TIME_BITS-1:0] d;
		logic [TIME_BITS-1:0] dur;
		int i;
		int r;
		for (i = 0; i < n; i++) begin
			if (i % 60 == 0) begin
				send_burst = ($urandom_range(0, 3) == 0);
				recv_burst = ($urandom_range(0, 3) == 0);
			end
			if (i == n / 2)
				timeline = $urandom_range(32'h8000_0000, 32'hF000_0000);
			if ($urandom_range(0, 99) < 8) begin
				// noise: arrivals out of order, departures below arrival
				a = $urandom;
				d = $urandom;
			end else begin
				if ($urandom_range(0, 99) == 0)
					timeline += $urandom_range(0, 1 << 20);
				else
					timeline += $urandom_range(0, 12);
				r = $urandom_range(0, 99);
				dur = (r < 10) ? 0 : (r < 92) ? $urandom_range(1, 120) :
					$urandom_range(121, 1 << 16);
				a = timeline;
				d = (timeline > TIME_MAX - dur) ? TIME_MAX : timeline + dur;
			end
			send_interval(a, d, TAG_BITS'($urandom));
		end
		send_burst = 1'b0;
		recv_burst = 1'b0;
	endtask

	// Receiver holds off while items keep coming, so the block backs up
	task automatic test_output_hold;
		int k;
		send_burst = 1'b1;
		hold_cycles = 250;
		for (k = 0; k < 12; k++) begin
			timeline += 3;
			send_interval(timeline, timeline + 20, TAG_BITS'($urandom));
		end
		send_burst = 1'b0;
	endtask

	task automatic test_fill_and_overflow;
		int k;
		k = 0;
		// arrival zero never finds a free room, so every item opens one
		while (heap_size < MAX_ROOMS) begin
			if (k % 100 == 0) begin
				send_burst = ($urandom_range(0, 2) == 0);
				recv_burst = ($urandom_range(0, 2) == 0);
			end
			send_interval('0, $urandom, TAG_BITS'($urandom));
			k++;
		end
		for (k = 0; k < 16; k++) begin
			if (k % 2 == 0)
				send_interval(heap_dep[0], $urandom, TAG_BITS'($urandom));
			else
				send_interval(TIME_MAX, $urandom, TAG_BITS'($urandom));
		end
		send_burst = 1'b0;
		recv_burst = 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_random_schedules(350);
		test_output_hold();
		test_random_schedules(60);
		test_fill_and_overflow();
		in_valid <= 1'b0;
		while (grants_due.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* files.f */
design/iral_pkg.sv
design/iral_ram.sv
design/iral_cmp.sv
design/interval_room_allocator.sv
sim/interval_room_allocator_tb.sv
